FILE: hdl/drive_command_framer_crc16_unit_macros.svh
// Assertion macros shared by the drive command framer modules.
`ifndef DRIVE_COMMAND_FRAMER_CRC16_UNIT_MACROS_SVH
`define DRIVE_COMMAND_FRAMER_CRC16_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DCF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define DCF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dcf_pkg.sv
// Types, constants and the CRC step function of the drive command framer.
package dcf_pkg;

  localparam int GAIN_W     = 10;
  localparam int RAW_W      = 16;
  localparam int GAIN_RESET = 256;
  localparam int LIMIT      = 1000;
  localparam int WEAKEN_MIN = 800;
  localparam int PULSE_OFF  = 3000;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SOF_CHAR = 8'h2F;
  localparam logic [7:0]  EOL_CHAR = 8'h0A;

  typedef struct packed {
    logic [RAW_W-1:0] speed_raw;
    logic [RAW_W-1:0] steer_raw;
    logic             upper_lamp_primary;
    logic             lower_lamp_primary;
    logic             switch_out_primary;
    logic             upper_lamp_secondary;
    logic             lower_lamp_secondary;
    logic             switch_out_secondary;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_out_t;

  // Classified command as it waits for the byte sequencer.
  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] steer;
    logic [7:0]  flags;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    B_SOF,
    B_SPD_HI,
    B_SPD_LO,
    B_STR_HI,
    B_STR_LO,
    B_FLAGS,
    B_CRC_HI,
    B_CRC_LO,
    B_EOL
  } byte_idx_e;

  // One byte of CRC-16/XMODEM, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/dcf_front.sv
// Front end: takes commands, scales and saturates speed and steer, builds flags.
module dcf_front import dcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [GAIN_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  cmd_t              in_data_i,
  output logic              in_stall_o,
  output logic              push_o,
  output entry_t            entry_o,
  input  q_status_t         q_status_i
);
`include "drive_command_framer_crc16_unit_macros.svh"

  logic [GAIN_W-1:0] gain_q;
  logic              s1_valid_q, s1_valid_d;
  logic signed [28:0] prod_q;
  logic [15:0]       steer_q;
  logic [5:0]        lamps_q;

  logic signed [17:0] spd_d, str_d;
  logic signed [28:0] prod_adj;
  logic signed [20:0] spd_div;
  logic signed [15:0] speed_sat, steer_sat;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(GAIN_RESET);
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign in_stall_o = s1_valid_q && q_status_i.full;
  assign push_o     = s1_valid_q && !q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Pulse to signed offset value: 2*raw - 3000.
  assign spd_d = $signed({1'b0, in_data_i.speed_raw, 1'b0}) - 18'sd3000;
  assign str_d = $signed({1'b0, in_data_i.steer_raw, 1'b0}) - 18'sd3000;

  always_comb begin
    if (str_d > 18'(LIMIT)) begin
      steer_sat = 16'(LIMIT);
    end else if (str_d < -18'sd1000) begin
      steer_sat = -16'sd1000;
    end else begin
      steer_sat = str_d[15:0];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Both factors are widened to the product width before the multiply.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= 29'(spd_d) * 29'($signed({1'b0, gain_q}));
      steer_q <= steer_sat;
      lamps_q <= {in_data_i.switch_out_secondary, in_data_i.lower_lamp_secondary,
                  in_data_i.upper_lamp_secondary, in_data_i.switch_out_primary,
                  in_data_i.lower_lamp_primary, in_data_i.upper_lamp_primary};
    end
  end

  // Divide by 256 rounding toward zero, then clamp.
  assign prod_adj = prod_q + (prod_q[28] ? 29'sd255 : 29'sd0);
  assign spd_div  = prod_adj[28:8];

  always_comb begin
    if (spd_div > 21'(LIMIT)) begin
      speed_sat = 16'(LIMIT);
    end else if (spd_div < -21'sd1000) begin
      speed_sat = -16'sd1000;
    end else begin
      speed_sat = spd_div[15:0];
    end
  end

  assign entry_o.speed = speed_sat;
  assign entry_o.steer = steer_q;
  assign entry_o.flags = {(speed_sat > 16'(WEAKEN_MIN)), speed_sat[15], lamps_q};

  `DCF_ASSERT_IMPL(a_stall_needs_item, in_stall_o, s1_valid_q, "front stalls with no item held")

endmodule

FILE: hdl/dcf_queue.sv
// Short queue of classified commands between front end and byte sequencer.
module dcf_queue import dcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    entry_i,
  input  logic      pop_i,
  output entry_t    head_o,
  output q_status_t status_o
);
`include "drive_command_framer_crc16_unit_macros.svh"

  entry_t            slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  `DCF_ASSERT_IMPL(a_no_pop_empty, pop_i, !status_o.empty, "pop from empty queue")
  `DCF_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule

FILE: hdl/dcf_back.sv
// Byte sequencer: emits the nine frame bytes and accumulates the CRC.
module dcf_back import dcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output frame_out_t out_data_o,
  input  logic       out_stall_i
);
`include "drive_command_framer_crc16_unit_macros.svh"

  byte_idx_e  state_q, state_d;
  entry_t     hold_q;
  logic [15:0] crc_q, crc_d;
  frame_out_t out_q;
  logic       out_valid_q;
  logic       can_send, send;
  logic [7:0] byte_sel;
  logic       last_sel;

  assign can_send = !out_valid_q || !out_stall_i;
  assign send     = can_send && ((state_q != B_SOF) || !q_status_i.empty);
  assign pop_o    = send && (state_q == B_SOF);

  always_comb begin
    state_d = state_q;
    if (send) begin
      unique case (state_q)
        B_SOF:    state_d = B_SPD_HI;
        B_SPD_HI: state_d = B_SPD_LO;
        B_SPD_LO: state_d = B_STR_HI;
        B_STR_HI: state_d = B_STR_LO;
        B_STR_LO: state_d = B_FLAGS;
        B_FLAGS:  state_d = B_CRC_HI;
        B_CRC_HI: state_d = B_CRC_LO;
        B_CRC_LO: state_d = B_EOL;
        B_EOL:    state_d = B_SOF;
        default:  state_d = B_SOF;
      endcase
    end
  end

  always_comb begin
    last_sel = 1'b0;
    unique case (state_q)
      B_SOF:    byte_sel = SOF_CHAR;
      B_SPD_HI: byte_sel = hold_q.speed[15:8];
      B_SPD_LO: byte_sel = hold_q.speed[7:0];
      B_STR_HI: byte_sel = hold_q.steer[15:8];
      B_STR_LO: byte_sel = hold_q.steer[7:0];
      B_FLAGS:  byte_sel = hold_q.flags;
      B_CRC_HI: byte_sel = crc_q[15:8];
      B_CRC_LO: byte_sel = crc_q[7:0];
      B_EOL: begin
        byte_sel = EOL_CHAR;
        last_sel = 1'b1;
      end
      default:  byte_sel = SOF_CHAR;
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (send) begin
      unique case (state_q)
        B_SOF:                                      crc_d = crc16_byte(16'h0000, SOF_CHAR);
        B_SPD_HI, B_SPD_LO, B_STR_HI, B_STR_LO, B_FLAGS: crc_d = crc16_byte(crc_q, byte_sel);
        default:                                    crc_d = crc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_SOF;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (send) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (pop_o) begin
      hold_q <= head_i;
    end
    if (send) begin
      out_q.frame_byte <= byte_sel;
      out_q.last_byte  <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DCF_ASSERT_IMPL(a_last_is_eol, out_valid_q && out_q.last_byte,
                   out_q.frame_byte == EOL_CHAR, "last beat is not the newline")
  `DCF_ASSERT_NEXT(a_eol_wraps, send && (state_q == B_EOL),
                   state_q == B_SOF && out_q.last_byte, "frame did not close after newline")

endmodule

FILE: hdl/drive_command_framer_crc16_unit.sv
// Top level of the drive command framer: front end, queue and byte sequencer.
//
// Usage: each beat on the input channel (in_valid_i / in_stall_o, payload in_data_i)
// is one drive command. The block answers with nine beats on the output channel
// (out_valid_o / out_stall_i, payload out_data_o): '/', speed high and low, steer
// high and low, the flag byte, CRC-16/XMODEM high and low, and a newline that
// carries last_byte. Speed is (2*raw-3000) times the gain, divided by 256 toward
// zero and clamped to +-1000; steer is 2*raw-3000 clamped to +-1000.
// The gain register is written through cfg_valid_i / cfg_data_i; cfg_ready_o is
// always high, and writes belong in idle periods.
// A command passes through the front register and a queue slot, and its frame
// bytes then leave one at a time through the output register, which is the
// single output byte lane that limits how fast frames can go out.
// The front end keeps taking commands while a frame is going out, until the
// two-entry queue and its own register are full; then in_stall_o rises.
// When the receiver raises out_stall_i, the output beat holds and the sequencer
// pauses; commands back up into the queue and then stall the input.
// Reset clears the queue, the sequencer and the output valid, and sets the gain
// to 256 (unity).
module drive_command_framer_crc16_unit import dcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [GAIN_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cmd_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output frame_out_t        out_data_o
);

  logic      push, pop;
  entry_t    entry, head;
  q_status_t q_status;

  // The register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  dcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (entry),
    .q_status_i (q_status)
  );

  dcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(q_status)
  );

  dcf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

FILE: tb/dcf_frame_check.sv
// Frame predictor and comparator that watches the drive command framer channels.
module dcf_frame_check import dcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [GAIN_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  cmd_t              in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  frame_out_t        out_data_i,
  output int                pending_o,
  output int                errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [GAIN_W-1:0] gain;
  frame_out_t        frame_bytes_due[$];
  int                fail_count = 0;

  assign errors_o = fail_count;

  function automatic longint clamp_limit(input longint v);
    if (v > LIMIT) begin
      return LIMIT;
    end else if (v < -LIMIT) begin
      return -LIMIT;
    end
    return v;
  endfunction

  // Builds the nine frame bytes of one command, first byte in the top slot.
  function automatic logic [8:0][7:0] frame_for_command(input cmd_t c,
                                                        input logic [GAIN_W-1:0] g);
    longint      speed;
    longint      steer;
    logic [7:0]  flags;
    logic [47:0] body;
    logic [15:0] crc;
    logic        fb;
    speed = clamp_limit(((2 * longint'(c.speed_raw) - PULSE_OFF) * longint'(g)) / 256);
    steer = clamp_limit(2 * longint'(c.steer_raw) - PULSE_OFF);
    flags = {speed > WEAKEN_MIN, speed < 0,
             c.switch_out_secondary, c.lower_lamp_secondary, c.upper_lamp_secondary,
             c.switch_out_primary, c.lower_lamp_primary, c.upper_lamp_primary};
    body  = {SOF_CHAR, speed[15:0], steer[15:0], flags};
    // The CRC runs over the message one bit at a time, most significant first.
    crc = 16'h0000;
    for (int i = 47; i >= 0; i--) begin
      fb  = crc[15] ^ body[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return {body, crc, EOL_CHAR};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [8:0][7:0] frame;
    frame_out_t      due;
    if (!rst_ni) begin
      gain = GAIN_W'(GAIN_RESET);
      frame_bytes_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        gain = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (frame_bytes_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                   $time, out_data_i.frame_byte, out_data_i.last_byte);
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_data_i.frame_byte !== due.frame_byte) begin
            fail_count++;
            $display("%0t: frame_byte expected %h actual %h",
                     $time, due.frame_byte, out_data_i.frame_byte);
          end
          if (out_data_i.last_byte !== due.last_byte) begin
            fail_count++;
            $display("%0t: last_byte expected %b actual %b",
                     $time, due.last_byte, out_data_i.last_byte);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        frame = frame_for_command(in_data_i, gain);
        for (int k = 8; k >= 0; k--) begin
          frame_bytes_due.push_back('{frame_byte: frame[k], last_byte: k == 0});
        end
      end
      pending_o <= frame_bytes_due.size();
    end
  end

endmodule

FILE: tb/drive_command_framer_crc16_unit_test.sv
// Top of the drive command framer testbench: clock, reset, stimulus and verdict.
module drive_command_framer_crc16_unit_test;
  import dcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without a single beat on any channel before the run is given up.
  localparam int STALL_LIMIT = 1000;
  // Length of the one long receiver hold-off that fills the block up.
  localparam int LONG_HOLD   = 80;
  // Random beats per gain setting; five settings make up the random part.
  localparam int PHASE_BEATS = 82;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [GAIN_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  cmd_t              in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  frame_out_t        out_data_o;

  int   pending_bytes;
  int   mismatch_count;
  int   quiet_cycles = 0;
  // Set while both sides are to run without idling.
  logic calm         = 1'b0;
  // Each increment asks the receiver for one long hold-off.
  int   hold_reqs    = 0;

  always #4 clk_i = ~clk_i;

  drive_command_framer_crc16_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  dcf_frame_check i_frame_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .pending_o   (pending_bytes),
    .errors_o    (mismatch_count)
  );

  // The watchdog restarts its count on every beat of any channel. A hang in the
  // block, or a frame that never completes, ends the run here.
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL drive_command_framer_crc16_unit");
      $finish;
    end
  end

  // The receiver stalls about a quarter of the cycles unless the stimulus asks
  // for calm. When a long hold-off is requested, it counts the stretch itself,
  // so the sender keeps offering commands into a block that cannot drain.
  initial begin : receiver
    int served;
    served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != served) begin
        served++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(99) < 26);
    end
  end

  function automatic cmd_t make_cmd(input logic [15:0] speed_raw,
                                    input logic [15:0] steer_raw,
                                    input logic [5:0]  lamps);
    return cmd_t'({speed_raw, steer_raw, lamps[0], lamps[1], lamps[2],
                   lamps[3], lamps[4], lamps[5]});
  endfunction

  // Raw pulse values are mostly nominal, with some close to the center, where
  // the scaled speed is small and truncation matters, and some anywhere at all.
  function automatic logic [15:0] pick_raw();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      return 16'($urandom_range(2000, 1000));
    end else if (pick == 6) begin
      return 16'($urandom_range(1510, 1490));
    end else if (pick == 7) begin
      return 16'($urandom_range(2100, 900));
    end else if (pick == 8) begin
      return 16'($urandom_range(65535));
    end
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'd1000;
      default: return 16'd2000;
    endcase
  endfunction

  // Offers one command beat and returns at the edge that accepts it. Valid only
  // drops for a gap chosen before the beat, so it never falls and rises in one step.
  task automatic send_cmd(input cmd_t c);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering commands until every expected frame byte has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bytes != 0);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [GAIN_W-1:0] phase_gain [5];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats under the reset gain of unity: center, extremes of both raw
    // fields, the saturation points, the weakening threshold on both sides and
    // each lamp and switch bit on its own.
    send_cmd(make_cmd(16'd1500, 16'd1500, 6'h00));
    send_cmd(make_cmd(16'h0000, 16'h0000, 6'h3F));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 6'h00));
    send_cmd(make_cmd(16'd1000, 16'd2000, 6'h01));
    send_cmd(make_cmd(16'd2000, 16'd1000, 6'h02));
    send_cmd(make_cmd(16'd1900, 16'd1100, 6'h04));
    send_cmd(make_cmd(16'd1901, 16'd1901, 6'h08));
    send_cmd(make_cmd(16'd1499, 16'd1501, 6'h10));
    send_cmd(make_cmd(16'd1501, 16'd1499, 6'h20));
    send_cmd(make_cmd(16'h8000, 16'h7FFF, 6'h2A));
    send_cmd(make_cmd(16'h00FF, 16'hFF00, 6'h15));
    drain();

    // With zero gain the speed is always zero, whatever the raw pulse.
    write_gain(10'd0);
    send_cmd(make_cmd(16'd2000, 16'd1500, 6'h00));
    send_cmd(make_cmd(16'h0000, 16'h0000, 6'h00));
    send_cmd(make_cmd(16'hFFFF, 16'hFFFF, 6'h3F));
    drain();

    // Largest gain: small negative products truncate toward zero, and the
    // weakening threshold falls between nearby raw values.
    write_gain(10'd1023);
    send_cmd(make_cmd(16'd1499, 16'd1500, 6'h00));
    send_cmd(make_cmd(16'd1501, 16'd1500, 6'h00));
    send_cmd(make_cmd(16'd1600, 16'd1250, 6'h0F));
    send_cmd(make_cmd(16'd1601, 16'd1750, 6'h30));
    send_cmd(make_cmd(16'd1000, 16'd0,    6'h00));
    send_cmd(make_cmd(16'hFFFF, 16'd3000, 6'h3F));
    drain();

    // Random part: one gain setting per phase, the block drained in between.
    phase_gain[0] = 10'd1023;
    phase_gain[1] = 10'd384;
    phase_gain[2] = 10'd1;
    phase_gain[3] = 10'($urandom_range(1023));
    phase_gain[4] = 10'($urandom_range(1023));
    for (int p = 0; p < 5; p++) begin
      write_gain(phase_gain[p]);
      // The second phase opens with the long hold-off, the third runs without
      // any idling on either side.
      if (p == 1) begin
        hold_reqs <= hold_reqs + 1;
      end
      calm <= (p == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_cmd(make_cmd(pick_raw(), pick_raw(), 6'($urandom_range(63))));
      end
      drain();
    end

    // A final wait catches any stray beat after the last frame.
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS drive_command_framer_crc16_unit");
    end else begin
      $display("FAIL drive_command_framer_crc16_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/dcf_pkg.sv
hdl/dcf_front.sv
hdl/dcf_queue.sv
hdl/dcf_back.sv
hdl/drive_command_framer_crc16_unit.sv
tb/dcf_frame_check.sv
tb/drive_command_framer_crc16_unit_test.sv
